// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vp8roc_pkg.sv -----
// shared types, widths and codes for the vp8 reference and output control unit
package vp8roc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int ACTION_W = 2;
    localparam int COPY_W   = 2;
    localparam int DIM_W    = 14;
    localparam int PIC_W    = 16;
    localparam int DLY_W    = 4;
    localparam int KIND_W   = 3;
    localparam int SLOT_N   = 3;

    localparam int SLOT_LAST   = 0;
    localparam int SLOT_GOLDEN = 1;
    localparam int SLOT_ALT    = 2;

    localparam logic [COPY_W-1:0] COPY_FROM_LAST  = 2'd1;
    localparam logic [COPY_W-1:0] COPY_FROM_OTHER = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FRAME = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_OUTPUT    = 3'd0,
        KIND_DROPPED   = 3'd1,
        KIND_DECODED   = 3'd2,
        KIND_QUEUED    = 3'd3,
        KIND_PARSE_ERR = 3'd4,
        KIND_DRAINED   = 3'd5,
        KIND_FLUSHED   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        PIC_ZERO = 2'd0,
        PIC_ID   = 2'd1,
        PIC_RAM  = 2'd2
    } pic_sel_t;

    typedef struct packed {
        logic     load;
        logic     apply;
        logic     clear_ref;
        logic     flush;
        logic     push;
        logic     rd;
        logic     pop;
        logic     keep_delay;
        logic     emit;
        kind_t    kind;
        pic_sel_t pic_sel;
        logic     last;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    parse_ok;
        logic    drop;
        logic    new_seq;
        logic    show;
        logic    more;
        logic    last_pop;
        logic    status_last;
    } dp_status_t;

endpackage

// ----- src/vp8roc_ram.sv -----
// generic single write port ram with registered read
module vp8roc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/vp8roc_dp.sv -----
// datapath: frame state, reference slots, output queue and result registers
`include "assert_macros.svh"

module vp8roc_dp import vp8roc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DLY_W-1:0]    cfg_data,
    input  logic [ACTION_W-1:0] action,
    input  logic                parse_ok,
    input  logic                is_key,
    input  logic [DIM_W-1:0]    frame_width,
    input  logic [DIM_W-1:0]    frame_height,
    input  logic                shown,
    input  logic                refresh_alternate,
    input  logic [COPY_W-1:0]   copy_to_alternate,
    input  logic                refresh_golden,
    input  logic [COPY_W-1:0]   copy_to_golden,
    input  logic                refresh_last_ref,
    input  logic [PIC_W-1:0]    picture_id,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic [KIND_W-1:0]   kind,
    output logic                seq_start,
    output logic [PIC_W-1:0]    out_picture,
    output logic [PIC_W-1:0]    last_slot,
    output logic [PIC_W-1:0]    golden_slot,
    output logic [PIC_W-1:0]    alt_slot,
    output logic [SLOT_N-1:0]   slots_valid,
    output logic                end_of_run
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = ((CNT_W > DLY_W) ? CNT_W : DLY_W) + 1;

    // configuration and sequence state
    logic [DLY_W-1:0]  out_delay_reg, out_delay_next;
    logic              waiting_reg, waiting_next;
    logic              seen_reg, seen_next;
    logic [DIM_W-1:0]  cur_w_reg, cur_w_next;
    logic [DIM_W-1:0]  cur_h_reg, cur_h_next;
    logic [DLY_W-1:0]  act_dly_reg, act_dly_next;
    logic              newseq_reg, newseq_next;

    // reference slots
    logic [SLOT_N-1:0]  ref_valid_reg, ref_valid_next;
    logic [ID_BITS-1:0] ref_id_reg [SLOT_N];
    logic [ID_BITS-1:0] ref_id_next [SLOT_N];

    // output queue pointers
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // latched item
    logic [ACTION_W-1:0] act_reg;
    logic                parse_ok_reg;
    logic                key_reg;
    logic [DIM_W-1:0]    w_reg;
    logic [DIM_W-1:0]    h_reg;
    logic                show_reg;
    logic                ra_reg;
    logic [COPY_W-1:0]   ca_reg;
    logic                rg_reg;
    logic [COPY_W-1:0]   cg_reg;
    logic                rl_reg;
    logic [ID_BITS-1:0]  id_reg;

    // result registers
    kind_t               kind_reg, kind_next;
    logic                nseq_out_reg, nseq_out_next;
    logic [PIC_W-1:0]    pic_out_reg, pic_out_next;
    logic                end_reg, end_next;

    logic [ID_BITS-1:0] alt_upd, gold_upd, last_upd;
    logic               alt_v_upd, gold_v_upd, last_v_upd;
    logic               new_seq;
    logic [DLY_W-1:0]   dly_capped;
    logic [CMP_W-1:0]   cnt_x, keep_x;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_addr;
    logic [ID_BITS-1:0] ram_rd_data;

    assign new_seq = key_reg && ((w_reg != cur_w_reg) || (h_reg != cur_h_reg) || !seen_reg);

    assign dly_capped = (CMP_W'(out_delay_reg) > CMP_W'(QUEUE_DEPTH - 1))
                      ? DLY_W'(QUEUE_DEPTH - 1) : out_delay_reg;

    assign cnt_x  = CMP_W'(count_reg);
    assign keep_x = cmd.keep_delay ? CMP_W'(act_dly_reg) : '0;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_addr = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

    always_comb
    begin
        status.action      = action_t'(act_reg);
        status.parse_ok    = parse_ok_reg;
        status.drop        = waiting_reg && !key_reg;
        status.new_seq     = new_seq;
        status.show        = show_reg;
        status.more        = cnt_x > keep_x;
        status.last_pop    = cnt_x == (keep_x + CMP_W'(1));
        status.status_last = !show_reg || (cnt_x < CMP_W'(act_dly_reg));
    end

    // alternate first, then golden (which may copy the new alternate), then last
    always_comb
    begin
        alt_upd   = ref_id_reg[SLOT_ALT];
        alt_v_upd = ref_valid_reg[SLOT_ALT];
        if (ra_reg)
        begin
            alt_upd   = id_reg;
            alt_v_upd = 1'b1;
        end
        else if (ca_reg == COPY_FROM_LAST)
        begin
            alt_upd   = ref_id_reg[SLOT_LAST];
            alt_v_upd = ref_valid_reg[SLOT_LAST];
        end
        else if (ca_reg == COPY_FROM_OTHER)
        begin
            alt_upd   = ref_id_reg[SLOT_GOLDEN];
            alt_v_upd = ref_valid_reg[SLOT_GOLDEN];
        end

        gold_upd   = ref_id_reg[SLOT_GOLDEN];
        gold_v_upd = ref_valid_reg[SLOT_GOLDEN];
        if (rg_reg)
        begin
            gold_upd   = id_reg;
            gold_v_upd = 1'b1;
        end
        else if (cg_reg == COPY_FROM_LAST)
        begin
            gold_upd   = ref_id_reg[SLOT_LAST];
            gold_v_upd = ref_valid_reg[SLOT_LAST];
        end
        else if (cg_reg == COPY_FROM_OTHER)
        begin
            gold_upd   = alt_upd;
            gold_v_upd = alt_v_upd;
        end

        last_upd   = ref_id_reg[SLOT_LAST];
        last_v_upd = ref_valid_reg[SLOT_LAST];
        if (rl_reg)
        begin
            last_upd   = id_reg;
            last_v_upd = 1'b1;
        end
    end

    always_comb
    begin
        out_delay_next = out_delay_reg;
        waiting_next   = waiting_reg;
        seen_next      = seen_reg;
        cur_w_next     = cur_w_reg;
        cur_h_next     = cur_h_reg;
        act_dly_next   = act_dly_reg;
        newseq_next    = newseq_reg;
        ref_valid_next = ref_valid_reg;
        ref_id_next    = ref_id_reg;
        head_next      = head_reg;
        count_next     = count_reg;

        if (cfg_we)
        begin
            out_delay_next = cfg_data;
        end

        if (cmd.apply)
        begin
            waiting_next = 1'b0;
            newseq_next  = new_seq;
            if (key_reg)
            begin
                cur_w_next               = w_reg;
                cur_h_next               = h_reg;
                ref_valid_next           = '1;
                ref_id_next[SLOT_LAST]   = id_reg;
                ref_id_next[SLOT_GOLDEN] = id_reg;
                ref_id_next[SLOT_ALT]    = id_reg;
                if (new_seq)
                begin
                    seen_next    = 1'b1;
                    act_dly_next = dly_capped;
                end
            end
            else
            begin
                ref_id_next[SLOT_LAST]   = last_upd;
                ref_id_next[SLOT_GOLDEN] = gold_upd;
                ref_id_next[SLOT_ALT]    = alt_upd;
                ref_valid_next           = {alt_v_upd, gold_v_upd, last_v_upd};
            end
        end

        if (cmd.clear_ref)
        begin
            waiting_next   = 1'b1;
            ref_valid_next = '0;
        end

        if (cmd.flush)
        begin
            head_next  = '0;
            count_next = '0;
        end

        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.pop)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        kind_next     = kind_reg;
        nseq_out_next = nseq_out_reg;
        pic_out_next  = pic_out_reg;
        end_next      = end_reg;
        if (cmd.emit)
        begin
            kind_next     = cmd.kind;
            nseq_out_next = ((cmd.kind == KIND_QUEUED) || (cmd.kind == KIND_DECODED))
                          && newseq_reg;
            end_next      = cmd.last;
            case (cmd.pic_sel)
                PIC_ID:   pic_out_next = PIC_W'(id_reg);
                PIC_RAM:  pic_out_next = PIC_W'(ram_rd_data);
                default:  pic_out_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_delay_reg <= '0;
            waiting_reg   <= 1'b1;
            seen_reg      <= 1'b0;
            cur_w_reg     <= '0;
            cur_h_reg     <= '0;
            act_dly_reg   <= '0;
            newseq_reg    <= 1'b0;
            ref_valid_reg <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            out_delay_reg <= out_delay_next;
            waiting_reg   <= waiting_next;
            seen_reg      <= seen_next;
            cur_w_reg     <= cur_w_next;
            cur_h_reg     <= cur_h_next;
            act_dly_reg   <= act_dly_next;
            newseq_reg    <= newseq_next;
            ref_valid_reg <= ref_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_id_reg   <= ref_id_next;
        kind_reg     <= kind_next;
        nseq_out_reg <= nseq_out_next;
        pic_out_reg  <= pic_out_next;
        end_reg      <= end_next;
        if (cmd.load)
        begin
            act_reg      <= action;
            parse_ok_reg <= parse_ok;
            key_reg      <= is_key;
            w_reg        <= frame_width;
            h_reg        <= frame_height;
            show_reg     <= shown;
            ra_reg       <= refresh_alternate;
            ca_reg       <= copy_to_alternate;
            rg_reg       <= refresh_golden;
            cg_reg       <= copy_to_golden;
            rl_reg       <= refresh_last_ref;
            id_reg       <= ID_BITS'(picture_id);
        end
    end

    vp8roc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_addr),
        .wr_data (id_reg),
        .rd_en   (cmd.rd),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign kind         = kind_reg;
    assign seq_start    = nseq_out_reg;
    assign out_picture  = pic_out_reg;
    assign end_of_run   = end_reg;
    assign slots_valid  = ref_valid_reg;
    assign last_slot    = ref_valid_reg[SLOT_LAST]   ? PIC_W'(ref_id_reg[SLOT_LAST])   : '0;
    assign golden_slot  = ref_valid_reg[SLOT_GOLDEN] ? PIC_W'(ref_id_reg[SLOT_GOLDEN]) : '0;
    assign alt_slot     = ref_valid_reg[SLOT_ALT]    ? PIC_W'(ref_id_reg[SLOT_ALT])    : '0;

    `ASSERT_NOW(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overrun")
    `ASSERT_IMPLY(a_pop_nonempty, cmd.pop, count_reg != '0, "pop from empty queue")
    `ASSERT_IMPLY(a_push_room, cmd.push, count_reg < CNT_W'(QUEUE_DEPTH), "push into full queue")

endmodule

// ----- src/vp8roc_ctrl.sv -----
// controller: sequences each item into datapath commands and result handshakes
`include "assert_macros.svh"

module vp8roc_ctrl import vp8roc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHECK,
        S_READ,
        S_STATUS
    } state_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_POST,
        PH_CMD
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = KIND_OUTPUT;
        cmd.pic_sel = PIC_ZERO;
        state_next  = state_reg;
        phase_next  = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    case (status.action)
                        ACT_FRAME:
                        begin
                            if (!status.parse_ok)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.kind    = KIND_PARSE_ERR;
                                cmd.pic_sel = PIC_ID;
                                cmd.last    = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else if (status.drop)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.kind    = KIND_DROPPED;
                                cmd.pic_sel = PIC_ID;
                                cmd.last    = 1'b1;
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                cmd.apply = 1'b1;
                                if (status.new_seq)
                                begin
                                    phase_next = PH_PRE;
                                    state_next = S_CHECK;
                                end
                                else
                                begin
                                    state_next = S_STATUS;
                                end
                            end
                        end
                        ACT_DRAIN:
                        begin
                            cmd.clear_ref = 1'b1;
                            phase_next    = PH_CMD;
                            state_next    = S_CHECK;
                        end
                        ACT_FLUSH:
                        begin
                            cmd.clear_ref = 1'b1;
                            cmd.flush     = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.kind      = KIND_FLUSHED;
                            cmd.last      = 1'b1;
                            state_next    = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                cmd.keep_delay = phase_reg == PH_POST;
                if (out_free)
                begin
                    if (status.more)
                    begin
                        cmd.rd     = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_PRE:
                            begin
                                state_next = S_STATUS;
                            end
                            PH_CMD:
                            begin
                                cmd.emit   = 1'b1;
                                cmd.kind   = KIND_DRAINED;
                                cmd.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_READ:
            begin
                cmd.keep_delay = phase_reg == PH_POST;
                cmd.emit       = 1'b1;
                cmd.kind       = KIND_OUTPUT;
                cmd.pic_sel    = PIC_RAM;
                cmd.pop        = 1'b1;
                cmd.last       = (phase_reg == PH_POST) && status.last_pop;
                state_next     = cmd.last ? S_IDLE : S_CHECK;
            end

            S_STATUS:
            begin
                cmd.emit    = 1'b1;
                cmd.kind    = status.show ? KIND_QUEUED : KIND_DECODED;
                cmd.pic_sel = PIC_ID;
                cmd.push    = status.show;
                cmd.last    = status.status_last;
                phase_next  = PH_POST;
                state_next  = status.status_last ? S_IDLE : S_CHECK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && out_stall) || cmd.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_PRE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLY(a_emit_free, cmd.emit, out_free, "result loaded over a pending item")
    `ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state_reg == S_IDLE, "busy after last result")
    `ASSERT_IMPLY(a_read_clear, state_reg == S_READ, !out_valid_reg, "read with result pending")

endmodule

// ----- src/vp8_reference_and_output_control_unit.sv -----
// top level of the vp8 reference and output control unit
// One item in flight at a time. A frame with a status result passes through acceptance,
// the decide step and the status step; each picture taken out of the output queue adds
// a check and a registered read of the queue ram, and a new sequence adds a drain check
// before the status step, while a parse error, a dropped frame, a flush or an ignored
// action ends at the decide step. The decide and check steps wait while the result side
// is stalled. The next item can be accepted while the final result of the previous one
// waits to be taken. Drain sends every queued picture then a drained item; flush discards
// the queue and sends a flushed item. No clearing pass is needed after reset.
module vp8_reference_and_output_control_unit import vp8roc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DLY_W-1:0]    output_delay,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic                parse_ok,
    input  logic                is_key,
    input  logic [DIM_W-1:0]    frame_width,
    input  logic [DIM_W-1:0]    frame_height,
    input  logic                shown,
    input  logic                refresh_alternate,
    input  logic [COPY_W-1:0]   copy_to_alternate,
    input  logic                refresh_golden,
    input  logic [COPY_W-1:0]   copy_to_golden,
    input  logic                refresh_last_ref,
    input  logic [PIC_W-1:0]    picture_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KIND_W-1:0]   kind,
    output logic                seq_start,
    output logic [PIC_W-1:0]    out_picture,
    output logic [PIC_W-1:0]    last_slot,
    output logic [PIC_W-1:0]    golden_slot,
    output logic [PIC_W-1:0]    alt_slot,
    output logic [SLOT_N-1:0]   slots_valid,
    output logic                end_of_run
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    vp8roc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    vp8roc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (output_delay),
        .action            (action),
        .parse_ok          (parse_ok),
        .is_key            (is_key),
        .frame_width       (frame_width),
        .frame_height      (frame_height),
        .shown             (shown),
        .refresh_alternate (refresh_alternate),
        .copy_to_alternate (copy_to_alternate),
        .refresh_golden    (refresh_golden),
        .copy_to_golden    (copy_to_golden),
        .refresh_last_ref  (refresh_last_ref),
        .picture_id        (picture_id),
        .cmd               (cmd),
        .status            (status),
        .kind              (kind),
        .seq_start         (seq_start),
        .out_picture       (out_picture),
        .last_slot         (last_slot),
        .golden_slot       (golden_slot),
        .alt_slot          (alt_slot),
        .slots_valid       (slots_valid),
        .end_of_run        (end_of_run)
    );

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the vp8 reference and output control unit
`timescale 1ns / 100ps

module tb_top import vp8roc_pkg::*; ();

    localparam logic [COPY_W-1:0] COPY_NONE    = 2'd0;
    localparam logic [COPY_W-1:0] COPY_IGNORED = 2'd3;
    localparam int DRAIN_GUARD = 50;

    typedef struct packed {
        action_t             action;
        logic                parse_ok;
        logic                is_key;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic                show;
        logic                ref_alt;
        logic [COPY_W-1:0]   copy_alt;
        logic                ref_gold;
        logic [COPY_W-1:0]   copy_gold;
        logic                ref_last;
        logic [PIC_W-1:0]    pic;
    } frame_hdr_t;

    typedef struct {
        kind_t               kind;
        logic                new_seq;
        logic [PIC_W-1:0]    pic;
        logic [PIC_W-1:0]    last_id;
        logic [PIC_W-1:0]    golden_id;
        logic [PIC_W-1:0]    alt_id;
        logic [SLOT_N-1:0]   valid_bits;
        logic                eor;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [DLY_W-1:0]    delay_wdata;
    logic                in_valid;
    logic                in_stall;
    frame_hdr_t          drv_hdr;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   kind;
    logic                seq_start;
    logic [PIC_W-1:0]    out_picture;
    logic [PIC_W-1:0]    last_slot;
    logic [PIC_W-1:0]    golden_slot;
    logic [PIC_W-1:0]    alt_slot;
    logic [SLOT_N-1:0]   slots_valid;
    logic                end_of_run;

    frame_hdr_t          hdr_queue[$];
    report_t             due_reports[$];
    report_t             step_reports[$];

    // predictor state
    logic [DLY_W-1:0]    delay_reg;
    logic                p_waiting;
    logic                p_seen;
    logic [DIM_W-1:0]    p_w;
    logic [DIM_W-1:0]    p_h;
    logic [DLY_W-1:0]    p_delay;
    logic [PIC_W-1:0]    p_slot[SLOT_N];
    logic [SLOT_N-1:0]   p_valid;
    logic [PIC_W-1:0]    p_queue[$];

    logic [DIM_W-1:0]    gen_w;
    logic [DIM_W-1:0]    gen_h;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  fail_count = 0;
    int                  items_taken = 0;
    int                  results_seen = 0;
    int                  seq_starts = 0;

    always #5 clk = ~clk;

    vp8_reference_and_output_control_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .output_delay      (delay_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (drv_hdr.action),
        .parse_ok          (drv_hdr.parse_ok),
        .is_key            (drv_hdr.is_key),
        .frame_width       (drv_hdr.w),
        .frame_height      (drv_hdr.h),
        .shown             (drv_hdr.show),
        .refresh_alternate (drv_hdr.ref_alt),
        .copy_to_alternate (drv_hdr.copy_alt),
        .refresh_golden    (drv_hdr.ref_gold),
        .copy_to_golden    (drv_hdr.copy_gold),
        .refresh_last_ref  (drv_hdr.ref_last),
        .picture_id        (drv_hdr.pic),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .seq_start         (seq_start),
        .out_picture       (out_picture),
        .last_slot         (last_slot),
        .golden_slot       (golden_slot),
        .alt_slot          (alt_slot),
        .slots_valid       (slots_valid),
        .end_of_run        (end_of_run)
    );

    function automatic void note_event(input kind_t k, input logic ns, input logic [PIC_W-1:0] id);
        report_t r;
        r.kind = k;
        r.new_seq = ns;
        r.pic = id;
        step_reports.push_back(r);
    endfunction

    function automatic void release_down_to(input int keep);
        while (p_queue.size() > keep)
            note_event(KIND_OUTPUT, 1'b0, p_queue.pop_front());
    endfunction

    function automatic void clear_refs();
        p_valid = '0;
        for (int s = 0; s < SLOT_N; s++)
            p_slot[s] = '0;
    endfunction

    function automatic void load_slot(input int dst, input logic [PIC_W-1:0] id);
        p_slot[dst] = id;
        p_valid[dst] = 1'b1;
    endfunction

    function automatic void copy_ref(input int dst, input int src);
        if (p_valid[src])
            load_slot(dst, p_slot[src]);
        else
        begin
            p_valid[dst] = 1'b0;
            p_slot[dst] = '0;
        end
    endfunction

    function automatic void decode_frame(input frame_hdr_t f);
        logic ns;
        ns = 1'b0;
        if (!f.parse_ok)
        begin
            note_event(KIND_PARSE_ERR, 1'b0, f.pic);
            return;
        end
        if (p_waiting && !f.is_key)
        begin
            note_event(KIND_DROPPED, 1'b0, f.pic);
            return;
        end
        p_waiting = 1'b0;
        if (f.is_key)
        begin
            if (f.w != p_w || f.h != p_h || !p_seen)
            begin
                release_down_to(0);
                clear_refs();
                p_seen = 1'b1;
                p_delay = delay_reg;
                ns = 1'b1;
                seq_starts++;
            end
            p_w = f.w;
            p_h = f.h;
            load_slot(SLOT_LAST, f.pic);
            load_slot(SLOT_GOLDEN, f.pic);
            load_slot(SLOT_ALT, f.pic);
        end
        else
        begin
            if (f.ref_alt)
                load_slot(SLOT_ALT, f.pic);
            else if (f.copy_alt == COPY_FROM_LAST)
                copy_ref(SLOT_ALT, SLOT_LAST);
            else if (f.copy_alt == COPY_FROM_OTHER)
                copy_ref(SLOT_ALT, SLOT_GOLDEN);
            if (f.ref_gold)
                load_slot(SLOT_GOLDEN, f.pic);
            else if (f.copy_gold == COPY_FROM_LAST)
                copy_ref(SLOT_GOLDEN, SLOT_LAST);
            else if (f.copy_gold == COPY_FROM_OTHER)
                copy_ref(SLOT_GOLDEN, SLOT_ALT);
            if (f.ref_last)
                load_slot(SLOT_LAST, f.pic);
        end
        if (!f.show)
            note_event(KIND_DECODED, ns, f.pic);
        else
        begin
            if (p_queue.size() >= QUEUE_DEPTH_DEF)
                release_down_to(QUEUE_DEPTH_DEF - 1);
            p_queue.push_back(f.pic);
            note_event(KIND_QUEUED, ns, f.pic);
        end
        release_down_to(p_delay);
    endfunction

    // works out every result one header causes and appends them to due_reports
    function automatic void predict_frame_control(input frame_hdr_t f);
        report_t r;
        step_reports.delete();
        case (f.action)
            ACT_FRAME: decode_frame(f);
            ACT_DRAIN:
            begin
                release_down_to(0);
                clear_refs();
                p_waiting = 1'b1;
                note_event(KIND_DRAINED, 1'b0, '0);
            end
            ACT_FLUSH:
            begin
                p_queue.delete();
                clear_refs();
                p_waiting = 1'b1;
                note_event(KIND_FLUSHED, 1'b0, '0);
            end
            default: ;
        endcase
        for (int k = 0; k < step_reports.size(); k++)
        begin
            r = step_reports[k];
            r.last_id = p_valid[SLOT_LAST] ? p_slot[SLOT_LAST] : '0;
            r.golden_id = p_valid[SLOT_GOLDEN] ? p_slot[SLOT_GOLDEN] : '0;
            r.alt_id = p_valid[SLOT_ALT] ? p_slot[SLOT_ALT] : '0;
            r.valid_bits = p_valid;
            r.eor = (k == step_reports.size() - 1);
            due_reports.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : hdr_drive
        bit busy;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_hdr <= '0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_frame_control(drv_hdr);
                items_taken++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (hdr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_hdr <= hdr_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : result_check
        report_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (due_reports.size() == 0)
                begin
                    $error("unexpected item: kind %0d picture %0h", kind, out_picture);
                    fail_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("seq_start", want.new_seq, seq_start);
                    check_field("out_picture", want.pic, out_picture);
                    check_field("last_slot", want.last_id, last_slot);
                    check_field("golden_slot", want.golden_id, golden_slot);
                    check_field("alt_slot", want.alt_id, alt_slot);
                    check_field("slots_valid", want.valid_bits, slots_valid);
                    check_field("end_of_run", want.eor, end_of_run);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic frame_hdr_t hdr_frame(input logic key, input logic show,
                                             input logic [PIC_W-1:0] id);
        frame_hdr_t f;
        f = '0;
        f.action = ACT_FRAME;
        f.parse_ok = 1'b1;
        f.is_key = key;
        f.w = gen_w;
        f.h = gen_h;
        f.show = show;
        f.pic = id;
        return f;
    endfunction

    function automatic frame_hdr_t hdr_cmd(input action_t a);
        frame_hdr_t f;
        f = '0;
        f.action = a;
        return f;
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (hdr_queue.size() != 0 || in_valid || due_reports.size() != 0);
        repeat (DRAIN_GUARD) @(posedge clk);
    endtask

    task automatic set_output_delay(input logic [DLY_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        delay_wdata <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        delay_reg = v;
    endtask

    task automatic queue_random(input int target);
        frame_hdr_t f;
        int added;
        int pick;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if ($urandom_range(3) == 0)
                begin
                    gen_w = DIM_W'($urandom_range(16383));
                    gen_h = DIM_W'($urandom_range(16383));
                end
                hdr_queue.push_back(hdr_frame(1'b1, $urandom_range(3) != 0,
                                              PIC_W'($urandom_range(65535))));
                added++;
                repeat ($urandom_range(1, 20))
                begin
                    f = hdr_frame(1'b0, $urandom_range(4) != 0, PIC_W'($urandom_range(65535)));
                    f.parse_ok = ($urandom_range(19) != 0);
                    f.w = DIM_W'($urandom_range(16383));
                    f.h = DIM_W'($urandom_range(16383));
                    f.ref_alt = ($urandom_range(1) != 0);
                    f.copy_alt = COPY_W'($urandom_range(3));
                    f.ref_gold = ($urandom_range(1) != 0);
                    f.copy_gold = COPY_W'($urandom_range(3));
                    f.ref_last = ($urandom_range(1) != 0);
                    // occasional keyframe at the running size, no new sequence
                    if ($urandom_range(15) == 0)
                    begin
                        f.is_key = 1'b1;
                        f.w = gen_w;
                        f.h = gen_h;
                    end
                    hdr_queue.push_back(f);
                    added++;
                end
            end
            else if (pick < 87)
            begin
                hdr_queue.push_back(hdr_cmd($urandom_range(1) ? ACT_DRAIN : ACT_FLUSH));
                added++;
            end
            else
            begin
                f.action = action_t'(ACTION_W'($urandom_range(3)));
                f.parse_ok = ($urandom_range(1) != 0);
                f.is_key = ($urandom_range(1) != 0);
                f.w = DIM_W'($urandom_range(16383));
                f.h = DIM_W'($urandom_range(16383));
                f.show = ($urandom_range(1) != 0);
                f.ref_alt = ($urandom_range(1) != 0);
                f.copy_alt = COPY_W'($urandom_range(3));
                f.ref_gold = ($urandom_range(1) != 0);
                f.copy_gold = COPY_W'($urandom_range(3));
                f.ref_last = ($urandom_range(1) != 0);
                f.pic = PIC_W'($urandom_range(65535));
                hdr_queue.push_back(f);
                if (f.action != ACT_NONE)
                    added++;
            end
        end
    endtask

    initial
    begin : run_phases
        frame_hdr_t f;
        int send_pct[4];
        int stall_set[4];
        logic [DLY_W-1:0] delay_set[4];
        send_pct = '{0, 55, 0, 8};
        stall_set = '{0, 0, 55, 8};
        delay_set = '{4'd15, 4'd0, DLY_W'($urandom_range(1, 14)), DLY_W'($urandom_range(15))};
        cfg_valid <= 1'b0;
        delay_wdata <= '0;
        delay_reg = '0;
        p_waiting = 1'b1;
        p_seen = 1'b0;
        p_w = '0;
        p_h = '0;
        p_delay = '0;
        clear_refs();
        gen_w = 14'd640;
        gen_h = 14'd480;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_output_delay(4'd3);
        // directed
        f = hdr_frame(1'b0, 1'b1, 16'hFFFF);
        hdr_queue.push_back(f);
        f = hdr_frame(1'b1, 1'b1, 16'h0000);
        f.parse_ok = 1'b0;
        hdr_queue.push_back(f);
        f = '1;
        hdr_queue.push_back(f);
        gen_w = 14'h3FFF;
        gen_h = 14'h3FFF;
        hdr_queue.push_back(hdr_frame(1'b1, 1'b1, 16'd1));
        hdr_queue.push_back(hdr_frame(1'b1, 1'b0, 16'd2));
        f = hdr_frame(1'b0, 1'b1, 16'd3);
        f.ref_alt = 1'b1;
        f.copy_alt = COPY_FROM_LAST;
        hdr_queue.push_back(f);
        f = hdr_frame(1'b0, 1'b0, 16'd4);
        f.copy_alt = COPY_FROM_LAST;
        f.copy_gold = COPY_FROM_OTHER;
        hdr_queue.push_back(f);
        f = hdr_frame(1'b0, 1'b1, 16'd5);
        f.copy_alt = COPY_FROM_OTHER;
        f.copy_gold = COPY_FROM_LAST;
        f.ref_last = 1'b1;
        hdr_queue.push_back(f);
        f = hdr_frame(1'b0, 1'b1, 16'd6);
        f.copy_alt = COPY_IGNORED;
        f.copy_gold = COPY_IGNORED;
        hdr_queue.push_back(f);
        f = hdr_frame(1'b0, 1'b1, 16'd7);
        f.ref_alt = 1'b1;
        f.ref_gold = 1'b1;
        f.ref_last = 1'b1;
        f.copy_alt = COPY_NONE;
        hdr_queue.push_back(f);
        gen_w = '0;
        gen_h = '0;
        hdr_queue.push_back(hdr_frame(1'b1, 1'b1, 16'd8));
        f = hdr_frame(1'b0, 1'b1, 16'd9);
        f.parse_ok = 1'b0;
        hdr_queue.push_back(f);
        hdr_queue.push_back(hdr_frame(1'b0, 1'b1, 16'd10));
        hdr_queue.push_back(hdr_cmd(ACT_DRAIN));
        hdr_queue.push_back(hdr_frame(1'b0, 1'b1, 16'd11));
        gen_w = 14'd640;
        gen_h = 14'd480;
        hdr_queue.push_back(hdr_frame(1'b1, 1'b1, 16'd12));
        hdr_queue.push_back(hdr_frame(1'b0, 1'b1, 16'd13));
        hdr_queue.push_back(hdr_frame(1'b0, 1'b1, 16'd14));
        hdr_queue.push_back(hdr_cmd(ACT_FLUSH));
        // same size after a flush: sequence carries on
        hdr_queue.push_back(hdr_frame(1'b1, 1'b1, 16'd15));
        f = hdr_frame(1'b0, 1'b1, 16'hFFFF);
        f.ref_alt = 1'b1;
        f.ref_gold = 1'b1;
        f.ref_last = 1'b1;
        hdr_queue.push_back(f);
        hdr_queue.push_back(hdr_cmd(ACT_DRAIN));
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            set_output_delay(delay_set[p]);
            send_idle_pct = send_pct[p];
            stall_pct = stall_set[p];
            queue_random(85);
            wait_idle();
        end

        $display("%0d items accepted, %0d results checked, %0d new sequences",
                 items_taken, results_seen, seq_starts);
        $display("output delays 3, 15, 0 and two random settings, four idling mixes");
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
